// ===== src/smw_pkg.sv =====
// Shared definitions for the sliding window median unit.
// Holds default sizes, the configuration register layout and the cell command struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smw_pkg;

    localparam int WINDOW_MAX_DEF   = 32;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int              CFG_WIDTH = 6;
    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 6'd3;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        PH_INSERT = 2'b01,
        PH_EMIT   = 2'b10
    } phase_t;

endpackage

`default_nettype wire

// ===== src/smw_cell.sv =====
// One slot of the sorted window: holds a sample and its age.
// Shifts right on insertion and left on removal, talking to its neighbors and to the shared sample and control inputs.
// Depends on smw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smw_cell
    import smw_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FILL_W       = 6,
    parameter int AGE_W        = 5,
    parameter int INDEX        = 0
)
(
    input  wire logic                    clk,
    input  wire cell_cmd_t               cmd,
    input  wire logic [SAMPLE_WIDTH-1:0] sample,
    input  wire logic [FILL_W-1:0]       fill,
    input  wire logic [AGE_W-1:0]        oldest_age,
    input  wire logic [SAMPLE_WIDTH-1:0] left_val,
    input  wire logic [AGE_W-1:0]        left_age,
    input  wire logic                    left_gt,
    input  wire logic [SAMPLE_WIDTH-1:0] right_val,
    input  wire logic [AGE_W-1:0]        right_age,
    input  wire logic                    del_in,
    output logic      [SAMPLE_WIDTH-1:0] val,
    output logic      [AGE_W-1:0]        age,
    output logic                         gt,
    output logic                         del_out
);

    localparam logic [FILL_W-1:0] MY_IDX = FILL_W'(INDEX);

    logic [SAMPLE_WIDTH-1:0] val_reg;
    logic [SAMPLE_WIDTH-1:0] val_next;
    logic [AGE_W-1:0]        age_reg;
    logic [AGE_W-1:0]        age_next;
    logic                    occ;
    logic                    at_end;
    logic                    match;
    logic                    wr_en;

    assign occ     = MY_IDX < fill;
    assign at_end  = fill == MY_IDX;
    assign gt      = occ && ($signed(val_reg) > $signed(sample));
    assign match   = occ && (age_reg == oldest_age);
    assign del_out = del_in || match;

    always_comb
    begin
        val_next = val_reg;
        age_next = age_reg;
        wr_en    = 1'b0;
        if (cmd.ins)
        begin
            wr_en = occ || at_end;
            if (left_gt)
            begin
                val_next = left_val;
                age_next = left_age + AGE_W'(1);
            end
            else if (gt || at_end)
            begin
                val_next = sample;
                age_next = '0;
            end
            else
            begin
                age_next = age_reg + AGE_W'(1);
            end
        end
        else if (cmd.del)
        begin
            wr_en = occ && del_out;
            val_next = right_val;
            age_next = right_age;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

`default_nettype wire

// ===== src/sliding_window_median_unit.sv =====
// Top level of the sliding window median unit: control, window size register and output register.
// Instantiates a row of smw_cell slots kept in ascending order. Depends on smw_pkg and smw_cell.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_stall     sample, restart
//   output    out_valid / out_stall   median
//   config    cfg_write_en            cfg_write_data (window_size)
//
// A request that does not fill the window is one insert pass through the cell row.
// A request that fills it is the insert pass, then a pass that registers the median and
// removes the oldest sample, which waits while the output register holds an untaken result.
// Reset empties the window and sets the window size to 3; nothing needs clearing.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_unit
    import smw_pkg::*;
#(
    parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [SAMPLE_WIDTH-1:0] sample,
    input  wire logic                    restart,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic      [SAMPLE_WIDTH-1:0] median,
    input  wire logic                    cfg_write_en,
    input  wire logic [CFG_WIDTH-1:0]    cfg_write_data
);

    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int AGE_W  = IDX_W;
    localparam int CMP_W  = (FILL_W > CFG_WIDTH) ? FILL_W : CFG_WIDTH;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [CFG_WIDTH-1:0]    ws_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic                    out_valid_reg;
    logic [SAMPLE_WIDTH-1:0] median_reg;

    logic [CMP_W-1:0]        ws_ext;
    logic [CMP_W-1:0]        ws_clip;
    logic [FILL_W-1:0]       ws_eff;
    logic [FILL_W-1:0]       mid_full;
    logic [IDX_W-1:0]        mid_idx;
    logic [FILL_W-1:0]       fill_start;
    logic [FILL_W-1:0]       fill_ins;
    logic [FILL_W-1:0]       cell_fill;
    logic [FILL_W-1:0]       fill_less;
    logic [AGE_W-1:0]        oldest_age;
    logic                    accept;
    logic                    out_free;
    logic                    emit_fire;
    cell_cmd_t               cmd;

    logic [SAMPLE_WIDTH-1:0] cell_val [WINDOW_MAX];
    logic [AGE_W-1:0]        cell_age [WINDOW_MAX];
    logic                    cell_gt  [WINDOW_MAX];
    logic                    cell_del [WINDOW_MAX];

    always_comb
    begin
        ws_ext = CMP_W'(ws_reg);
        if (ws_ext == '0)
        begin
            ws_clip = CMP_W'(1);
        end
        else if (ws_ext > CMP_W'(WINDOW_MAX))
        begin
            ws_clip = CMP_W'(WINDOW_MAX);
        end
        else
        begin
            ws_clip = ws_ext;
        end
    end

    assign ws_eff   = ws_clip[FILL_W-1:0];
    assign mid_full = (ws_eff - FILL_W'(1)) >> 1;
    assign mid_idx  = mid_full[IDX_W-1:0];

    assign fill_start = (restart || (fill_reg >= ws_eff)) ? '0 : fill_reg;
    assign fill_ins   = fill_start + FILL_W'(1);
    assign fill_less  = fill_reg - FILL_W'(1);
    assign oldest_age = fill_less[AGE_W-1:0];

    assign in_stall  = (phase_reg != PH_INSERT);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = (phase_reg == PH_EMIT) && out_free;

    assign cmd.ins   = accept;
    assign cmd.del   = emit_fire;
    assign cell_fill = (phase_reg == PH_INSERT) ? fill_start : fill_reg;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            logic [SAMPLE_WIDTH-1:0] l_val;
            logic [AGE_W-1:0]        l_age;
            logic                    l_gt;
            logic                    l_del;
            logic [SAMPLE_WIDTH-1:0] r_val;
            logic [AGE_W-1:0]        r_age;

            if (gi == 0)
            begin : g_first
                assign l_val = '0;
                assign l_age = '0;
                assign l_gt  = 1'b0;
                assign l_del = 1'b0;
            end
            else
            begin : g_mid
                assign l_val = cell_val[gi-1];
                assign l_age = cell_age[gi-1];
                assign l_gt  = cell_gt[gi-1];
                assign l_del = cell_del[gi-1];
            end

            if (gi == WINDOW_MAX - 1)
            begin : g_last
                assign r_val = '0;
                assign r_age = '0;
            end
            else
            begin : g_inner
                assign r_val = cell_val[gi+1];
                assign r_age = cell_age[gi+1];
            end

            smw_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .FILL_W       (FILL_W),
                .AGE_W        (AGE_W),
                .INDEX        (gi)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .sample     (sample),
                .fill       (cell_fill),
                .oldest_age (oldest_age),
                .left_val   (l_val),
                .left_age   (l_age),
                .left_gt    (l_gt),
                .right_val  (r_val),
                .right_age  (r_age),
                .del_in     (l_del),
                .val        (cell_val[gi]),
                .age        (cell_age[gi]),
                .gt         (cell_gt[gi]),
                .del_out    (cell_del[gi])
            );
        end
    endgenerate

    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        unique case (phase_reg)
            PH_INSERT:
            begin
                if (accept)
                begin
                    fill_next = fill_ins;
                    if (fill_ins >= ws_eff)
                    begin
                        phase_next = PH_EMIT;
                    end
                end
            end
            PH_EMIT:
            begin
                if (out_free)
                begin
                    fill_next  = fill_less;
                    phase_next = PH_INSERT;
                end
            end
            default:
            begin
                phase_next = PH_INSERT;
            end
        endcase
        if (cfg_write_en)
        begin
            fill_next  = '0;
            phase_next = PH_INSERT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INSERT;
            ws_reg        <= WINDOW_SIZE_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            if (cfg_write_en)
            begin
                ws_reg <= cfg_write_data;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            median_reg <= cell_val[mid_idx];
        end
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;

endmodule

`default_nettype wire
